FILE: design/sacl_pkg.sv
// Shared types and constants for the set-associative cache lookup core.
// No dependencies; every other file imports this package.
package sacl_pkg;

  localparam int NUM_SETS   = 256;
  localparam int NUM_WAYS   = 8;
  localparam int SET_W      = $clog2(NUM_SETS);
  localparam int WAY_W      = $clog2(NUM_WAYS);
  localparam int AGE_W      = 3;
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int CNT_W      = 32;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPLACE_MODE  = 3'd0,
    CFG_ADDRESS_WIDTH = 3'd1,
    CFG_SET_BITS      = 3'd2,
    CFG_WAY_BITS      = 3'd3,
    CFG_OFFSET_BITS   = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    MODE_LRU  = 1'b0,
    MODE_FIFO = 1'b1
  } replace_mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;

  typedef struct packed {
    logic [NUM_WAYS-1:0]            valid;
    logic [NUM_WAYS-1:0][AGE_W-1:0] age;
  } meta_row_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [WAY_W-1:0] way;
    logic             tag_we;
    meta_row_t        meta_next;
    tag_row_t         tags_next;
  } decision_t;

endpackage

FILE: design/set_assoc_cache_lookup_lru_fifo_core.sv
// Set-associative cache lookup core with LRU or FIFO replacement.
// Sequence: the accepting edge reads the set row and enters LOOKUP; done,
// hit, evicted and way_used are registered at the write-back edge in LOOKUP.
// A new transaction is taken only in IDLE, once the read-modify-write
// of the set row in the tag and meta memories (read, then decide and write) is over.
// Reset: synchronous; clears configuration to defaults, counters, all lines.
// The result is shown for one cycle only; the receiver cannot stall.
module set_assoc_cache_lookup_lru_fifo_core
  import sacl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // lookup command
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_W-1:0]     address,
  // result
  output logic                  done,
  output logic                  hit,
  output logic                  evicted,
  output logic [WAY_W-1:0]      way_used,
  output logic [CNT_W-1:0]      hit_count,
  output logic [CNT_W-1:0]      miss_count,
  output logic [CNT_W-1:0]      eviction_count,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic       replace_mode;
  logic [5:0] address_width;
  logic [3:0] set_bits;
  logic [1:0] way_bits;
  logic [3:0] offset_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode  <= MODE_LRU;
      address_width <= 6'd32;
      set_bits      <= 4'd4;
      way_bits      <= 2'd1;
      offset_bits   <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLACE_MODE:  replace_mode  <= cfg_data[0];
        CFG_ADDRESS_WIDTH: address_width <= cfg_data;
        CFG_SET_BITS:      set_bits      <= cfg_data[3:0];
        CFG_WAY_BITS:      way_bits      <= cfg_data[1:0];
        CFG_OFFSET_BITS:   offset_bits   <= cfg_data[3:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Address split. Bits above address_width are dropped (widths beyond
  // 32 behave as 32), then the block number is the address without its
  // offset. The set index is the low set_bits of the block, wrapped to
  // the sets the memories hold. The stored tag is the whole block number.
  // ---------------------------------------------------------------------
  logic [ADDR_W-1:0] addr_mask;
  logic [ADDR_W-1:0] block_in;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_in;

  always_comb begin
    if (address_width >= 6'(ADDR_W)) begin
      addr_mask = '1;
    end else begin
      addr_mask = ~({ADDR_W{1'b1}} << address_width);
    end
    block_in = (address & addr_mask) >> offset_bits;
    if (set_bits >= 4'(SET_W)) begin
      set_mask = '1;
    end else begin
      set_mask = ~({SET_W{1'b1}} << set_bits);
    end
    set_in = block_in[SET_W-1:0] & set_mask;
  end

  // ---------------------------------------------------------------------
  // Control: IDLE accepts a transaction and launches the row read;
  // LOOKUP sees the row, decides and writes it back in the same cycle.
  // The write lands before any later read, so no forwarding is needed.
  // ---------------------------------------------------------------------
  state_t            state;
  state_t            state_next;
  logic              accept;
  logic [TAG_W-1:0]  block_q;
  logic [SET_W-1:0]  set_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    busy       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          accept     = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        busy       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      block_q <= block_in;
      set_q   <= set_in;
    end
  end

  // ---------------------------------------------------------------------
  // Set row storage and decision
  // ---------------------------------------------------------------------
  tag_row_t  tag_row;
  meta_row_t meta_row;
  decision_t dec;
  logic      wb;

  assign wb = (state == ST_LOOKUP);

  sacl_tag_mem u_tag_mem (
    .clk    (clk),
    .rd_en  (accept),
    .rd_set (set_in),
    .rd_row (tag_row),
    .wr_en  (wb && dec.tag_we),
    .wr_set (set_q),
    .wr_row (dec.tags_next)
  );

  sacl_meta_mem u_meta_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_set (set_in),
    .rd_row (meta_row),
    .wr_en  (wb),
    .wr_set (set_q),
    .wr_row (dec.meta_next)
  );

  sacl_decide u_decide (
    .block        (block_q),
    .way_bits     (way_bits),
    .replace_mode (replace_mode),
    .tags         (tag_row),
    .meta         (meta_row),
    .dec          (dec)
  );

  // ---------------------------------------------------------------------
  // Running totals (saturating) and result registers. The totals drive
  // the count outputs directly; they only move on the write-back edge,
  // so they hold steady while done is high.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
      done           <= 1'b0;
    end else begin
      done <= wb;
      if (wb) begin
        if (dec.hit) begin
          if (hit_count != '1) begin
            hit_count <= hit_count + 1'b1;
          end
        end else if (miss_count != '1) begin
          miss_count <= miss_count + 1'b1;
        end
        if (dec.evicted && eviction_count != '1) begin
          eviction_count <= eviction_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb) begin
      hit      <= dec.hit;
      evicted  <= dec.evicted;
      way_used <= dec.way;
    end
  end

endmodule

FILE: design/sacl_tag_mem.sv
// Tag store: one row of NUM_WAYS tags per set, registered read.
// Depends on sacl_pkg. Contents undefined until written.
module sacl_tag_mem
  import sacl_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [SET_W-1:0] rd_set,
  output tag_row_t         rd_row,
  input  logic             wr_en,
  input  logic [SET_W-1:0] wr_set,
  input  tag_row_t         wr_row
);

  tag_row_t mem [NUM_SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_set];
    end
  end

endmodule

FILE: design/sacl_meta_mem.sv
// Valid and age store, one row per set, registered read.
// Depends on sacl_pkg. A per-row flag makes unwritten rows read as zero.
module sacl_meta_mem
  import sacl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [SET_W-1:0] rd_set,
  output meta_row_t        rd_row,
  input  logic             wr_en,
  input  logic [SET_W-1:0] wr_set,
  input  meta_row_t        wr_row
);

  meta_row_t           mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_written;
  meta_row_t           rd_data;
  logic                rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_data <= mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
      rd_written  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_written[wr_set] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= row_written[rd_set];
      end
    end
  end

  assign rd_row = rd_written ? rd_data : '0;

endmodule

FILE: design/sacl_decide.sv
// Hit/miss decision for one set row: tag compare, free-way and victim
// search, age update. Depends on sacl_pkg. Purely combinational.
module sacl_decide
  import sacl_pkg::*;
(
  input  logic [TAG_W-1:0] block,
  input  logic [1:0]       way_bits,
  input  logic             replace_mode,
  input  tag_row_t         tags,
  input  meta_row_t        meta,
  output decision_t        dec
);

  logic [WAY_W:0]       way_cnt;
  logic [NUM_WAYS-1:0]  in_use;
  logic                 found;
  logic [WAY_W-1:0]     hit_way;
  logic                 has_free;
  logic [WAY_W-1:0]     free_way;
  logic [WAY_W-1:0]     victim;
  logic [WAY_W-1:0]     used;
  logic [AGE_W:0]       limit;
  logic                 do_age;

  assign way_cnt = (WAY_W+1)'(1) << way_bits;

  always_comb begin
    found    = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    victim   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      in_use[w] = (WAY_W+1)'(w) < way_cnt;
      if (in_use[w]) begin
        if (meta.valid[w]) begin
          if (!found && tags[w] == block) begin
            found   = 1'b1;
            hit_way = WAY_W'(w);
          end
        end else if (!has_free) begin
          has_free = 1'b1;
          free_way = WAY_W'(w);
        end
      end
    end
    // oldest line; strict compare keeps the lowest way on a tie
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (in_use[w] && meta.age[w] > meta.age[victim]) begin
        victim = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if (found) begin
      used = hit_way;
    end else if (has_free) begin
      used = free_way;
    end else begin
      used = victim;
    end
    limit  = found ? {1'b0, meta.age[hit_way]} : {1'b0, AGE_MAX} + 1'b1;
    do_age = !found || (replace_mode == MODE_LRU);

    dec.hit       = found;
    dec.evicted   = !found && !has_free;
    dec.way       = used;
    dec.tag_we    = !found;
    dec.meta_next = meta;
    dec.tags_next = tags;
    dec.tags_next[used] = block;
    if (do_age) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (in_use[w] && WAY_W'(w) != used && meta.valid[w] &&
            {1'b0, meta.age[w]} < limit && meta.age[w] != AGE_MAX) begin
          dec.meta_next.age[w] = meta.age[w] + 1'b1;
        end
      end
      dec.meta_next.age[used]   = '0;
      dec.meta_next.valid[used] = 1'b1;
    end
  end

endmodule
